>>> rtl/i2cm_pkg.sv
package i2cm_pkg;

	localparam int UNIT_W      = 16;
	localparam int TMO_W       = 8;
	localparam int BYTE_W      = 8;
	localparam int MODE_W      = 2;
	localparam int BIT_IDX_W   = 3;
	localparam int UNITS_W     = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [UNIT_W-1:0] RESET_UNIT_TICKS  = 16'd1;
	localparam logic [TMO_W-1:0]  RESET_ACK_TIMEOUT = 8'd250;

	// command modes
	localparam logic [MODE_W-1:0] MODE_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STOP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd1;

	// one tick after decode
	typedef struct packed {
		logic              is_start;
		logic              is_stop;
		logic              is_write;
		logic              is_read;
		logic [BYTE_W-1:0] tx_byte;
		logic              ack_after_read;
		logic              sda_in;
	} dec_item_t;

	typedef struct packed {
		logic              scl_level;
		logic              sda_level;
		logic              sda_drive;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] rx_byte;
		logic              nack;
	} res_item_t;

endpackage

>>> rtl/i2cm_if.sv
interface i2cm_cmd_if;
	import i2cm_pkg::*;
	logic              valid;
	logic              ready;
	logic              cmd_valid;
	logic [MODE_W-1:0] mode;
	logic [BYTE_W-1:0] tx_byte;
	logic              ack_after_read;
	logic              sda_in;

	modport source (output valid, cmd_valid, mode, tx_byte, ack_after_read, sda_in,
		input ready);
	modport sink (input valid, cmd_valid, mode, tx_byte, ack_after_read, sda_in,
		output ready);
endinterface

interface i2cm_res_if;
	import i2cm_pkg::*;
	logic              valid;
	logic              ready;
	logic              scl_level;
	logic              sda_level;
	logic              sda_drive;
	logic              busy_res;
	logic              done_res;
	logic [BYTE_W-1:0] rx_byte;
	logic              nack;

	modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, nack, input ready);
	modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, nack, output ready);
endinterface

interface i2cm_cfg_if;
	import i2cm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/i2cm_front.sv
module i2cm_front
	import i2cm_pkg::*;
(
	i2cm_cmd_if.sink  cmd,
	input  logic      queue_full,
	output logic      push,
	output dec_item_t push_item
);

	assign cmd.ready = !queue_full;
	assign push      = cmd.valid && !queue_full;

	// decode the mode into one flag per command, none when no command is offered
	always_comb begin
		push_item                = '0;
		push_item.tx_byte        = cmd.tx_byte;
		push_item.ack_after_read = cmd.ack_after_read;
		push_item.sda_in         = cmd.sda_in;
		if (cmd.cmd_valid) begin
			case (cmd.mode)
				MODE_START: push_item.is_start = 1'b1;
				MODE_STOP:  push_item.is_stop  = 1'b1;
				MODE_WRITE: push_item.is_write = 1'b1;
				MODE_READ:  push_item.is_read  = 1'b1;
				default:    push_item.is_start = 1'b0;
			endcase
		end
	end

endmodule

>>> rtl/i2cm_queue.sv
module i2cm_queue
	import i2cm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  dec_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      pop_valid,
	output dec_item_t pop_item
);

	dec_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

	logic do_pop;

	assign full      = (count_q == DEPTH_CNT);
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/i2cm_back.sv
module i2cm_back
	import i2cm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	i2cm_cfg_if.sink  cfg,
	input  logic      item_valid,
	input  dec_item_t item,
	output logic      pop,
	i2cm_res_if.source res
);

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_ST_A    = 4'd1;
	localparam logic [3:0] PH_ST_B    = 4'd2;
	localparam logic [3:0] PH_SP_A    = 4'd3;
	localparam logic [3:0] PH_SP_B    = 4'd4;
	localparam logic [3:0] PH_SP_C    = 4'd5;
	localparam logic [3:0] PH_WR_LOW  = 4'd6;
	localparam logic [3:0] PH_WR_DATA = 4'd7;
	localparam logic [3:0] PH_WR_HIGH = 4'd8;
	localparam logic [3:0] PH_AK_LOW  = 4'd9;
	localparam logic [3:0] PH_AK_HIGH = 4'd10;
	localparam logic [3:0] PH_POLL    = 4'd11;
	localparam logic [3:0] PH_RD_LOW  = 4'd12;
	localparam logic [3:0] PH_RD_HIGH = 4'd13;
	localparam logic [3:0] PH_RA_LOW  = 4'd14;
	localparam logic [3:0] PH_RA_HIGH = 4'd15;

	localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

	logic [UNIT_W-1:0]    unit_ticks_q;
	logic [TMO_W-1:0]     ack_timeout_q;

	logic [3:0]           phase_q,   n_phase;
	logic [BIT_IDX_W-1:0] bit_idx_q, n_bit_idx;
	logic [UNIT_W-1:0]    unit_cnt_q, n_unit_cnt;
	logic [UNITS_W-1:0]   units_q,   n_units;
	logic [BYTE_W-1:0]    shift_q,   n_shift;
	logic [TMO_W-1:0]     poll_q,    n_poll;
	logic                 rack_q,    n_rack;
	logic                 scl_q,     n_scl;
	logic                 sda_q,     n_sda;
	logic                 drv_q,     n_drv;
	logic                 nack_q,    n_nack;
	logic [BYTE_W-1:0]    rx_q,      n_rx;
	logic                 done;

	res_item_t            res_q;
	logic                 res_valid_q;
	logic                 advance;

	logic [UNIT_W-1:0]    tick_limit;
	logic [UNIT_W:0]      cnt_inc;
	logic [UNITS_W-1:0]   units_dec;
	logic [TMO_W:0]       poll_inc;
	logic                 expire;
	logic                 do_poll;

	assign cfg.ready = 1'b1;
	assign advance   = item_valid && (!res_valid_q || res.ready);
	assign pop       = advance;

	assign tick_limit = (unit_ticks_q == '0) ? UNIT_W'(1) : unit_ticks_q;
	assign cnt_inc    = {1'b0, unit_cnt_q} + 1'b1;
	assign units_dec  = (units_q != '0) ? units_q - 1'b1 : '0;
	assign poll_inc   = {1'b0, poll_q} + 1'b1;

	always_comb begin
		n_phase    = phase_q;
		n_bit_idx  = bit_idx_q;
		n_unit_cnt = unit_cnt_q;
		n_units    = units_q;
		n_shift    = shift_q;
		n_poll     = poll_q;
		n_rack     = rack_q;
		n_scl      = scl_q;
		n_sda      = sda_q;
		n_drv      = drv_q;
		n_nack     = nack_q;
		n_rx       = rx_q;
		done       = 1'b0;
		expire     = 1'b0;
		do_poll    = 1'b0;

		if (phase_q == PH_IDLE) begin
			n_bit_idx  = '0;
			n_unit_cnt = '0;
			if (item.is_start) begin
				n_drv = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
				n_phase = PH_ST_A; n_units = 2'd2;
			end else if (item.is_stop) begin
				n_drv = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
				n_phase = PH_SP_A; n_units = 2'd2;
			end else if (item.is_write) begin
				n_drv = 1'b1; n_scl = 1'b0;
				n_shift = item.tx_byte;
				n_nack = 1'b0; n_poll = '0;
				n_phase = PH_WR_LOW; n_units = 2'd1;
			end else if (item.is_read) begin
				n_drv = 1'b0; n_sda = 1'b1; n_scl = 1'b0;
				n_shift = '0;
				n_rack = item.ack_after_read;
				n_phase = PH_RD_LOW; n_units = 2'd2;
			end else begin
				n_bit_idx  = bit_idx_q;
				n_unit_cnt = unit_cnt_q;
			end
		end else if (phase_q == PH_POLL) begin
			do_poll = 1'b1;
		end else if (cnt_inc >= {1'b0, tick_limit}) begin
			n_unit_cnt = '0;
			n_units    = units_dec;
			expire     = (units_dec == '0);
		end else begin
			n_unit_cnt = cnt_inc[UNIT_W-1:0];
		end

		// hold time of the current phase has run out
		if (expire) begin
			case (phase_q)
				PH_ST_A: begin
					n_sda = 1'b0; n_phase = PH_ST_B; n_units = 2'd2;
				end
				PH_ST_B: begin
					n_scl = 1'b0; n_phase = PH_IDLE; done = 1'b1;
				end
				PH_SP_A: begin
					n_scl = 1'b1; n_phase = PH_SP_B; n_units = 2'd1;
				end
				PH_SP_B: begin
					n_sda = 1'b1; n_phase = PH_SP_C; n_units = 2'd2;
				end
				PH_SP_C: begin
					n_phase = PH_IDLE; done = 1'b1;
				end
				PH_WR_LOW: begin
					n_sda = shift_q[BYTE_W-1];
					n_shift = {shift_q[BYTE_W-2:0], 1'b0};
					n_phase = PH_WR_DATA; n_units = 2'd1;
				end
				PH_WR_DATA: begin
					n_scl = 1'b1; n_phase = PH_WR_HIGH; n_units = 2'd2;
				end
				PH_WR_HIGH: begin
					n_scl = 1'b0;
					if (bit_idx_q == LAST_BIT) begin
						n_drv = 1'b0; n_sda = 1'b1; n_poll = '0;
						n_phase = PH_AK_LOW; n_units = 2'd1;
					end else begin
						n_bit_idx = bit_idx_q + 1'b1;
						n_phase = PH_WR_LOW; n_units = 2'd1;
					end
				end
				PH_AK_LOW: begin
					n_scl = 1'b1; n_phase = PH_AK_HIGH; n_units = 2'd1;
				end
				PH_AK_HIGH: begin
					do_poll = 1'b1;
				end
				PH_RD_LOW: begin
					n_scl = 1'b1; n_phase = PH_RD_HIGH; n_units = 2'd2;
				end
				PH_RD_HIGH: begin
					n_shift = {shift_q[BYTE_W-2:0], item.sda_in};
					n_scl = 1'b0;
					if (bit_idx_q == LAST_BIT) begin
						n_drv = 1'b1; n_sda = !rack_q;
						n_phase = PH_RA_LOW; n_units = 2'd2;
					end else begin
						n_bit_idx = bit_idx_q + 1'b1;
						n_phase = PH_RD_LOW; n_units = 2'd2;
					end
				end
				PH_RA_LOW: begin
					n_scl = 1'b1; n_phase = PH_RA_HIGH; n_units = 2'd2;
				end
				PH_RA_HIGH: begin
					n_scl = 1'b0; n_rx = shift_q; n_phase = PH_IDLE; done = 1'b1;
				end
				default: begin
					n_phase = PH_IDLE;
				end
			endcase
		end

		// acknowledge poll, shared by the ack high phase and the poll phase
		if (do_poll) begin
			if (!item.sda_in) begin
				n_scl = 1'b0; n_nack = 1'b0; n_phase = PH_IDLE; done = 1'b1;
			end else if (poll_inc > {1'b0, ack_timeout_q}) begin
				n_drv = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
				n_nack = 1'b1; n_poll = '0;
				n_phase = PH_SP_A; n_units = 2'd2; n_unit_cnt = '0;
			end else begin
				n_poll = poll_inc[TMO_W-1:0];
				n_phase = PH_POLL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q  <= RESET_UNIT_TICKS;
			ack_timeout_q <= RESET_ACK_TIMEOUT;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_UNIT_TICKS:  unit_ticks_q  <= cfg.data[UNIT_W-1:0];
				REG_ACK_TIMEOUT: ack_timeout_q <= cfg.data[TMO_W-1:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_idx_q   <= '0;
			unit_cnt_q  <= '0;
			units_q     <= '0;
			shift_q     <= '0;
			poll_q      <= '0;
			rack_q      <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			drv_q       <= 1'b1;
			nack_q      <= 1'b0;
			rx_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q    <= n_phase;
				bit_idx_q  <= n_bit_idx;
				unit_cnt_q <= n_unit_cnt;
				units_q    <= n_units;
				shift_q    <= n_shift;
				poll_q     <= n_poll;
				rack_q     <= n_rack;
				scl_q      <= n_scl;
				sda_q      <= n_sda;
				drv_q      <= n_drv;
				nack_q     <= n_nack;
				rx_q       <= n_rx;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.scl_level <= n_scl;
			res_q.sda_level <= n_drv ? n_sda : 1'b1;
			res_q.sda_drive <= n_drv;
			res_q.busy_res  <= (n_phase != PH_IDLE);
			res_q.done_res  <= done;
			res_q.rx_byte   <= n_rx;
			res_q.nack      <= n_nack;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.scl_level = res_q.scl_level;
	assign res.sda_level = res_q.sda_level;
	assign res.sda_drive = res_q.sda_drive;
	assign res.busy_res  = res_q.busy_res;
	assign res.done_res  = res_q.done_res;
	assign res.rx_byte   = res_q.rx_byte;
	assign res.nack      = res_q.nack;

endmodule

>>> rtl/i2c_master_byte_engine_unit.sv
// channel  role    handshake      payload
// cmd      sink    valid/ready    cmd_valid, mode, tx_byte, ack_after_read, sda_in
// res      source  valid/ready    scl_level, sda_level, sda_drive, busy_res, done_res,
//                                 rx_byte, nack
// cfg      sink    valid/ready    index (0 unit_ticks, 1 ack_timeout), data
//
// one tick item per clock sustained while res is not stalled; the sequencer state update is the single-cycle loop
// an accepted item passes the decode queue and then the output register before its result is shown
// the two-entry queue keeps cmd ready while res is stalled, until the queue fills
// arst_n clears the sequencer to idle with scl, sda high and driven; cfg ready is always high
module i2c_master_byte_engine_unit
	import i2cm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	i2cm_cmd_if.sink   cmd,
	i2cm_res_if.source res,
	i2cm_cfg_if.sink   cfg
);

	logic      push;
	dec_item_t push_item;
	logic      queue_full;
	logic      pop;
	logic      pop_valid;
	dec_item_t pop_item;

	i2cm_front u_front (
		.cmd        (cmd),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	i2cm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_item  (pop_item)
	);

	i2cm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (pop_valid),
		.item       (pop_item),
		.pop        (pop),
		.res        (res)
	);

endmodule
